// ===== src/ppfl_pkg.sv =====
// Shared types and constants for the particle pool free-list core.
package ppfl_pkg;

  localparam int POOL_SLOTS = 100;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int OUT_W      = 7;

  localparam logic FUNC_CREATE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [1:0] ST_CREATED = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_TICK    = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [15:0]        life_ticks;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OUT_W-1:0] slot;
    logic [OUT_W-1:0] freed_count;
    logic [OUT_W-1:0] live_count;
  } out_t;

  // Per-slot control word: lifetime and free-list link.
  typedef struct packed {
    logic [15:0]       frames;
    logic [SLOT_W-1:0] nxt;
    logic              nxt_valid;
  } ctrl_entry_t;

  // Per-slot kinematics.
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
  } kin_entry_t;

  typedef struct packed {
    logic              ctrl_en;
    logic              kin_en;
    logic [SLOT_W-1:0] addr;
    ctrl_entry_t       ctrl;
    kin_entry_t        kin;
  } mem_wr_t;

endpackage

// ===== src/particle_pool_free_list_core.sv =====
// Top level: free-list allocator and per-tick slot walker over the slot memories.
// A create does one memory read of the head slot's link, then the write;
// a create on a full pool answers in the cycle after the transfer.
// A tick walks all POOL_SLOTS slots at one slot per cycle through the slot
// memory read port. After reset the block is busy while the link memory is
// initialized.
// Each result appears for one cycle with done high; it cannot be stalled.
module particle_pool_free_list_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ppfl_pkg::in_t  cmd,
  output logic           busy,
  output logic           done,
  output ppfl_pkg::out_t result
);
  import ppfl_pkg::*;

  typedef enum logic [3:0] {
    S_INIT = 4'b0001,
    S_IDLE = 4'b0010,
    S_CRT  = 4'b0100,
    S_TICK = 4'b1000
  } state_t;

  state_t            state;
  in_t               req;
  logic [SLOT_W-1:0] head;
  logic              head_valid;
  logic [CNT_W-1:0]  live_total;
  logic [CNT_W-1:0]  freed;
  logic [CNT_W-1:0]  issue_idx;
  logic              proc_valid;
  logic [SLOT_W-1:0] proc_idx;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  mem_wr_t           wr;
  ctrl_entry_t       ctrl_q;
  kin_entry_t        kin_q;
  logic              store_ready;

  logic              accept;
  logic              issuing;
  logic              proc_live;
  logic [15:0]       frames_next;
  logic              expiring;

  ppfl_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr      (wr),
    .ctrl_q  (ctrl_q),
    .kin_q   (kin_q),
    .ready   (store_ready)
  );

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign issuing     = (state == S_TICK) && (issue_idx != CNT_W'(POOL_SLOTS));
  assign proc_live   = proc_valid && (ctrl_q.frames != '0);
  assign frames_next = ctrl_q.frames - 16'd1;
  assign expiring    = proc_live && (frames_next == '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    if (accept && (cmd.func == FUNC_CREATE) && head_valid) begin
      rd_en = 1'b1;
    end else if (issuing) begin
      rd_en   = 1'b1;
      rd_addr = issue_idx[SLOT_W-1:0];
    end
  end

  always_comb begin
    wr = '0;
    if (state == S_CRT) begin
      wr.ctrl_en          = 1'b1;
      wr.kin_en           = 1'b1;
      wr.addr             = head;
      // zero lifetime is promoted to one tick
      wr.ctrl.frames      = (req.life_ticks == '0) ? 16'd1 : req.life_ticks;
      wr.ctrl.nxt         = ctrl_q.nxt;
      wr.ctrl.nxt_valid   = ctrl_q.nxt_valid;
      wr.kin.px           = req.pos_x;
      wr.kin.py           = req.pos_y;
      wr.kin.vx           = req.vel_x;
      wr.kin.vy           = req.vel_y;
    end else if (proc_live) begin
      wr.ctrl_en          = 1'b1;
      wr.kin_en           = 1'b1;
      wr.addr             = proc_idx;
      wr.ctrl.frames      = frames_next;
      // an expiring slot is pushed onto the front of the free list
      wr.ctrl.nxt         = expiring ? head : ctrl_q.nxt;
      wr.ctrl.nxt_valid   = expiring ? head_valid : ctrl_q.nxt_valid;
      wr.kin.px           = kin_q.px + kin_q.vx;
      wr.kin.py           = kin_q.py + kin_q.vy;
      wr.kin.vx           = kin_q.vx;
      wr.kin.vy           = kin_q.vy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      head       <= '0;
      head_valid <= 1'b1;
      live_total <= '0;
      freed      <= '0;
      issue_idx  <= '0;
      proc_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          if (store_ready) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req <= cmd;
            if (cmd.func == FUNC_TICK) begin
              issue_idx  <= '0;
              freed      <= '0;
              proc_valid <= 1'b0;
              state      <= S_TICK;
            end else if (head_valid) begin
              state <= S_CRT;
            end else begin
              done               <= 1'b1;
              result.status      <= ST_FULL;
              result.slot        <= '0;
              result.freed_count <= '0;
              result.live_count  <= OUT_W'(live_total);
            end
          end
        end
        S_CRT: begin
          head               <= ctrl_q.nxt;
          head_valid         <= ctrl_q.nxt_valid;
          live_total         <= live_total + 1'b1;
          done               <= 1'b1;
          result.status      <= ST_CREATED;
          result.slot        <= OUT_W'(head);
          result.freed_count <= '0;
          result.live_count  <= OUT_W'(live_total + 1'b1);
          state              <= S_IDLE;
        end
        S_TICK: begin
          proc_valid <= issuing;
          proc_idx   <= issue_idx[SLOT_W-1:0];
          if (issuing) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (expiring) begin
            head       <= proc_idx;
            head_valid <= 1'b1;
            freed      <= freed + 1'b1;
            if (live_total != '0) begin
              live_total <= live_total - 1'b1;
            end
          end
          // walk finished and last slot retired
          if (!issuing && !proc_valid) begin
            done               <= 1'b1;
            result.status      <= ST_TICK;
            result.slot        <= '0;
            result.freed_count <= OUT_W'(freed);
            result.live_count  <= OUT_W'(live_total);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

// ===== src/ppfl_store.sv =====
// Slot storage: control and kinematics memories plus the post-reset clearing pass.
module ppfl_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [ppfl_pkg::SLOT_W-1:0]   rd_addr,
  input  ppfl_pkg::mem_wr_t             wr,
  output ppfl_pkg::ctrl_entry_t         ctrl_q,
  output ppfl_pkg::kin_entry_t          kin_q,
  output logic                          ready
);
  import ppfl_pkg::*;

  ctrl_entry_t       ctrl_mem [POOL_SLOTS];
  kin_entry_t        kin_mem  [POOL_SLOTS];
  logic [SLOT_W-1:0] init_cnt;
  logic              init_last;
  ctrl_entry_t       init_entry;

  assign init_last = (init_cnt == SLOT_W'(POOL_SLOTS - 1));

  // Reset image: slot free, linked to the next slot, last link null.
  always_comb begin
    init_entry.frames    = '0;
    init_entry.nxt       = init_last ? '0 : init_cnt + 1'b1;
    init_entry.nxt_valid = !init_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      ready    <= 1'b0;
    end else if (!ready) begin
      init_cnt <= init_cnt + 1'b1;
      if (init_last) begin
        ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      ctrl_mem[init_cnt] <= init_entry;
    end else if (wr.ctrl_en) begin
      ctrl_mem[wr.addr] <= wr.ctrl;
    end
    if (rd_en) begin
      ctrl_q <= ctrl_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.kin_en) begin
      kin_mem[wr.addr] <= wr.kin;
    end
    if (rd_en) begin
      kin_q <= kin_mem[rd_addr];
    end
  end

endmodule

// ===== dv/particle_pool_free_list_core_tb.sv =====
// Self-checking testbench for the particle pool free-list core.
`timescale 1ns / 100ps

module particle_pool_free_list_core_tb;
  import ppfl_pkg::*;

  localparam int RAND_ITEMS = 1500;
  localparam int CALM_ITEMS = 200;      // closing stretch with no idle bursts
  localparam int WATCHDOG   = 2000;
  localparam int MAX_ROWS   = 24;

  logic clk;
  logic rst;
  logic start;
  in_t  cmd;
  logic busy;
  logic done;
  out_t result;

  particle_pool_free_list_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pool mirror. Positions and velocities never reach the result port, so
  // only lifetimes and free-list links are tracked.
  logic [15:0]       life_left [POOL_SLOTS];
  logic [SLOT_W-1:0] link      [POOL_SLOTS];
  logic              link_ok   [POOL_SLOTS];
  logic [SLOT_W-1:0] head;
  logic              head_ok;
  int                live;

  out_t pending_results[$];
  int   fail_cnt;
  int   idle_cycles;
  bit   gap_on;

  int n_create, n_full, n_tick, n_recycled, peak_live;

  // Directed stimulus table
  in_t  dir_cmd   [MAX_ROWS];
  int   dir_reps  [MAX_ROWS];
  bit   dir_typed [MAX_ROWS];
  out_t dir_want  [MAX_ROWS];
  int   n_rows;

  task automatic note_mismatch(input string what, input int got, input int want);
    fail_cnt++;
    $display("%0t MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic out_t pool_step(input in_t c);
    out_t              r;
    int                freed;
    logic [15:0]       life;
    logic [SLOT_W-1:0] s;
    r = '0;
    if (c.func == FUNC_CREATE) begin
      n_create++;
      if (!head_ok) begin
        n_full++;
        r.status = ST_FULL;
      end else begin
        s       = head;
        head_ok = link_ok[s];
        head    = link[s];
        // zero lifetime is promoted to one so the slot comes back next tick
        life = (c.life_ticks == 16'd0) ? 16'd1 : c.life_ticks;
        life_left[s] = life;
        live++;
        if (live > peak_live) peak_live = live;
        r.status = ST_CREATED;
        r.slot   = OUT_W'(s);
      end
    end else begin
      n_tick++;
      freed = 0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (life_left[i] != 16'd0) begin
          life_left[i] = life_left[i] - 16'd1;
          if (life_left[i] == 16'd0) begin
            // freed slot goes to the front of the free list
            link[i]    = head;
            link_ok[i] = head_ok;
            head       = SLOT_W'(i);
            head_ok    = 1'b1;
            freed++;
            if (live > 0) live--;
          end
        end
      end
      n_recycled += freed;
      r.status      = ST_TICK;
      r.freed_count = OUT_W'(freed);
    end
    r.live_count = OUT_W'(live);
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_life();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 16'd0;
    if (r < 64) return 16'($urandom_range(1, 6));
    if (r < 98) return 16'($urandom_range(7, 300));
    return 16'($urandom_range(16'h8000, 16'hFFFF));
  endfunction

  task automatic put_row(input logic f, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] dx, input logic [31:0] dy,
                         input logic [15:0] life, input int reps, input bit typed,
                         input logic [1:0] st, input int sl, input int fr, input int lv);
    dir_cmd[n_rows]   = '{func: f, pos_x: x, pos_y: y, vel_x: dx, vel_y: dy,
                          life_ticks: life};
    dir_reps[n_rows]  = reps;
    dir_typed[n_rows] = typed;
    dir_want[n_rows]  = '{status: st, slot: OUT_W'(sl), freed_count: OUT_W'(fr),
                          live_count: OUT_W'(lv)};
    n_rows++;
  endtask

  // One command transfer; an idle burst may come first. start stays high
  // into the next call unless that call opens with a burst.
  task automatic issue(input in_t c, input bit typed, input out_t want);
    out_t pred;
    if (gap_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    pred = pool_step(c);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending, status", result.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (result.status != want.status)
          note_mismatch("status", result.status, want.status);
        if (result.slot != want.slot)
          note_mismatch("slot", result.slot, want.slot);
        if (result.freed_count != want.freed_count)
          note_mismatch("freed_count", result.freed_count, want.freed_count);
        if (result.live_count != want.live_count)
          note_mismatch("live_count", result.live_count, want.live_count);
      end
    end
  end

  // Watchdog: cycles with neither a command transfer nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_t c;
    int  run;
    int  mode;
    int  n_rand;

    start <= 1'b0;
    cmd   <= '0;
    rst   <= 1'b1;
    fail_cnt    = 0;
    idle_cycles = 0;
    n_create = 0; n_full = 0; n_tick = 0; n_recycled = 0; peak_live = 0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      life_left[i] = 16'd0;
      link[i]      = SLOT_W'(i + 1);
      link_ok[i]   = (i + 1 < POOL_SLOTS);
    end
    link[POOL_SLOTS-1] = '0;
    head    = '0;
    head_ok = 1'b1;
    live    = 0;

    n_rows = 0;
    put_row(FUNC_CREATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            16'd1, 1, 1, ST_CREATED, 0, 0, 1);
    put_row(FUNC_CREATE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000,
            16'd0, 1, 1, ST_CREATED, 1, 0, 2);
    put_row(FUNC_CREATE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            16'hFFFF, 1, 1, ST_CREATED, 2, 0, 3);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 1, ST_TICK, 0, 2, 1);
    // freed slots are reused most recent first
    put_row(FUNC_CREATE, 32'h0, 32'h0, 32'h1, 32'h1, 16'd1, 1, 1, ST_CREATED, 1, 0, 2);
    put_row(FUNC_CREATE, 32'h0, 32'h0, 32'h1, 32'h1, 16'd1, 1, 1, ST_CREATED, 0, 0, 3);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 1, ST_TICK, 0, 2, 1);
    put_row(FUNC_TICK, '1, '1, '1, '1, '1, 1, 1, ST_TICK, 0, 0, 1);
    // fill the rest of the pool, then hit it while full
    put_row(FUNC_CREATE, '0, '0, '0, '0, 16'd3, POOL_SLOTS - 1, 0, ST_CREATED, 0, 0, 0);
    put_row(FUNC_CREATE, '1, '1, '1, '1, 16'd5, 1, 1, ST_FULL, 0, 0, POOL_SLOTS);
    put_row(FUNC_CREATE, '0, '0, '0, '0, 16'd0, 1, 1, ST_FULL, 0, 0, POOL_SLOTS);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 1, ST_TICK, 0, 0, POOL_SLOTS);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 1, ST_TICK, 0, 0, POOL_SLOTS);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 1, ST_TICK, 0, POOL_SLOTS - 1, 1);
    put_row(FUNC_CREATE, '0, '0, '0, '0, 16'd2, 4, 0, ST_CREATED, 0, 0, 0);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 1, 0, ST_TICK, 0, 0, 0);
    put_row(FUNC_CREATE, '0, '0, '0, '0, 16'd1, 1, 0, ST_CREATED, 0, 0, 0);
    put_row(FUNC_TICK, '0, '0, '0, '0, '0, 2, 0, ST_TICK, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    gap_on = 1'b1;
    for (int r = 0; r < n_rows; r++) begin
      for (int k = 0; k < dir_reps[r]; k++) begin
        c = dir_cmd[r];
        // repeated rows get fresh kinematics on every transfer
        if (dir_reps[r] > 1) begin
          c.pos_x = $urandom;
          c.pos_y = $urandom;
          c.vel_x = $urandom;
          c.vel_y = $urandom;
        end
        issue(c, dir_typed[r], dir_want[r]);
      end
    end

    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      if (n_rand >= RAND_ITEMS - CALM_ITEMS) gap_on = 1'b0;
      else if ($urandom_range(0, 15) == 0) gap_on = ~gap_on;
      mode = $urandom_range(0, 19);
      if (mode < 12)      run = $urandom_range(10, 40);   // mixed traffic
      else if (mode < 15) run = $urandom_range(20, 110);  // allocation burst
      else                run = $urandom_range(1, 12);    // tick run to drain
      for (int k = 0; k < run && n_rand < RAND_ITEMS; k++) begin
        if (mode < 12)      c.func = ($urandom_range(0, 9) < 6) ? FUNC_CREATE : FUNC_TICK;
        else if (mode < 15) c.func = FUNC_CREATE;
        else                c.func = FUNC_TICK;
        c.pos_x      = pick_word();
        c.pos_y      = pick_word();
        c.vel_x      = pick_word();
        c.vel_y      = pick_word();
        c.life_ticks = pick_life();
        issue(c, 1'b0, '0);
        n_rand++;
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (POOL_SLOTS + 8) @(posedge clk);

    $display("Ran %0d creates (%0d rejected on a full pool) and %0d ticks",
             n_create, n_full, n_tick);
    $display("Peak occupancy %0d of %0d slots, %0d slots recycled",
             peak_live, POOL_SLOTS, n_recycled);
    if (fail_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ppfl_pkg.sv
src/ppfl_store.sv
src/particle_pool_free_list_core.sv
dv/particle_pool_free_list_core_tb.sv
